FILE: src/fcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcl_pkg
// Shared types, sizes and codes of the training dense layer.
// ----------------------------------------------------------------------------
package fcl_pkg;

	localparam int IN_MAX    = 64;
	localparam int OUT_MAX   = 32;
	localparam int BATCH_MAX = 8;

	localparam int IN_W  = $clog2(IN_MAX);
	localparam int OUT_W = $clog2(OUT_MAX);
	localparam int SMP_W = $clog2(BATCH_MAX);

	localparam int W_AW = OUT_W + IN_W;
	localparam int X_AW = SMP_W + IN_W;
	localparam int G_AW = SMP_W + OUT_W;

	localparam int ACC_W = 38;
	localparam int DIV_W = 34;
	localparam int DIV_CW = 6;
	localparam int T_W   = DIV_W + 16;
	localparam int SAT_W = T_W + 2;

	localparam logic [2:0] MODE_WEIGHT = 3'd0;
	localparam logic [2:0] MODE_BIAS   = 3'd1;
	localparam logic [2:0] MODE_INPUT  = 3'd2;
	localparam logic [2:0] MODE_GRAD   = 3'd3;
	localparam logic [2:0] MODE_READ   = 3'd4;

	localparam logic [1:0] REG_INPUT_COUNT  = 2'd0;
	localparam logic [1:0] REG_OUTPUT_COUNT = 2'd1;
	localparam logic [1:0] REG_BATCH_COUNT  = 2'd2;
	localparam logic [1:0] REG_LEARN_RATE   = 2'd3;

	localparam logic KIND_FWD  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic [2:0]         mode;
		logic [2:0]         sample;
		logic [4:0]         row;
		logic [5:0]         col;
		logic signed [15:0] value;
	} in_item_t;

	typedef struct packed {
		logic               kind;
		logic [5:0]         index;
		logic signed [15:0] result;
		logic               last;
	} out_item_t;

	function automatic logic signed [15:0] sat16(input logic signed [SAT_W-1:0] v);
		logic signed [15:0] r;
		if (v > SAT_W'(32767))
			r = 16'sh7FFF;
		else if (v < -SAT_W'(32768))
			r = -16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

endpackage

FILE: src/fcl_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcl_div
// Restoring unsigned divider, one quotient bit per cycle, small divisor.
// ----------------------------------------------------------------------------
module fcl_div import fcl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [3:0]       divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	logic [DIV_W-1:0]  quo_q;
	logic [3:0]        rem_q;
	logic [3:0]        dsr_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [4:0]        trial;
	logic              ge;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CW'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? 4'(trial - {1'b0, dsr_q}) : trial[3:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: src/fully_connected_layer_train.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fully_connected_layer_train
// Dense layer, Q8.8, forward pass and batch SGD update on one shared MAC.
// Write, input and gradient items are taken in the idle state; a read passes RWAIT and ROUT.
// Forward pass: output_count results, each an input_count dot product plus bias.
// Backward pass: 512 entry sweep, an output_count dot product per active entry,
// then per row (input_count+1) updates: batch_count dot product, divide, scale, write.
// After reset a 512 entry pass clears the input gradient store; not ready.
// ----------------------------------------------------------------------------
module fully_connected_layer_train import fcl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_FDOT  = 4'd2;
	localparam logic [3:0] S_FFIN  = 4'd3;
	localparam logic [3:0] S_IDOT  = 4'd4;
	localparam logic [3:0] S_IFIN  = 4'd5;
	localparam logic [3:0] S_UDOT  = 4'd6;
	localparam logic [3:0] S_UDIV  = 4'd7;
	localparam logic [3:0] S_UWAIT = 4'd8;
	localparam logic [3:0] S_UMUL  = 4'd9;
	localparam logic [3:0] S_UAPP  = 4'd10;
	localparam logic [3:0] S_RWAIT = 4'd11;
	localparam logic [3:0] S_ROUT  = 4'd12;

	logic [6:0]  in_cnt_q;
	logic [5:0]  out_cnt_q;
	logic [3:0]  bat_cnt_q;
	logic [15:0] lr_q;
	logic [6:0]  ni;
	logic [5:0]  no;
	logic [3:0]  nb;

	logic [3:0]       state_q;
	logic [6:0]       k_q;
	logic [OUT_W-1:0] r_q;
	logic [IN_W-1:0]  c_q;
	logic [SMP_W-1:0] b_q;
	logic [SMP_W-1:0] s_q;
	logic             bias_q;
	logic             neg_q;

	logic signed [15:0] w_mem [OUT_MAX*IN_MAX];
	logic signed [15:0] b_mem [OUT_MAX];
	logic signed [15:0] x_mem [BATCH_MAX*IN_MAX];
	logic signed [15:0] g_mem [BATCH_MAX*OUT_MAX];
	logic signed [15:0] ig_mem [BATCH_MAX*IN_MAX];
	logic signed [15:0] w_rd_q, b_rd_q, x_rd_q, g_rd_q, ig_rd_q;

	logic signed [15:0]      opa, opb;
	logic signed [31:0]      p_s2;
	logic                    v_s1, v_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic [6:0]              len;
	logic                    dot_st, issue, drained;

	logic [DIV_W-1:0] quo;
	logic             div_done;
	logic [T_W-1:0]   t_q;

	logic accept, out_free, in_rng, nxt_rng;
	logic [SMP_W-1:0] nxt_b;
	logic [IN_W-1:0]  nxt_c;

	logic signed [ACC_W-1:0] f_full;
	logic signed [15:0]      f_res, i_res, u_res;
	logic [T_W:0]            dmag;
	logic signed [SAT_W-1:0] u_old, u_new;

	logic             w_we, b_we, ig_we;
	logic [W_AW-1:0]  w_wa, w_ra;
	logic [OUT_W-1:0] b_wa;
	logic [X_AW-1:0]  x_ra, ig_wa;
	logic [G_AW-1:0]  g_ra;
	logic signed [15:0] w_wd, b_wd, ig_wd;

	out_item_t out_q;
	logic      out_valid_q;

	assign ni = (in_cnt_q == 7'd0) ? 7'd1 :
		(in_cnt_q > 7'(IN_MAX)) ? 7'(IN_MAX) : in_cnt_q;
	assign no = (out_cnt_q == 6'd0) ? 6'd1 :
		(out_cnt_q > 6'(OUT_MAX)) ? 6'(OUT_MAX) : out_cnt_q;
	assign nb = (bat_cnt_q == 4'd0) ? 4'd1 :
		(bat_cnt_q > 4'(BATCH_MAX)) ? 4'(BATCH_MAX) : bat_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q  <= 7'd64;
			out_cnt_q <= 6'd32;
			bat_cnt_q <= 4'd1;
			lr_q      <= 16'd655;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INPUT_COUNT:  in_cnt_q  <= cfg_data[6:0];
				REG_OUTPUT_COUNT: out_cnt_q <= cfg_data[5:0];
				REG_BATCH_COUNT:  bat_cnt_q <= cfg_data[3:0];
				REG_LEARN_RATE:   lr_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// MAC pipeline: memory read, product, accumulate
	assign dot_st  = (state_q == S_FDOT) || (state_q == S_IDOT) || (state_q == S_UDOT);
	assign len     = (state_q == S_FDOT) ? ni :
		(state_q == S_IDOT) ? {1'b0, no} : {3'b0, nb};
	assign issue   = dot_st && (k_q < len);
	assign drained = dot_st && !issue && !v_s1 && !v_s2;

	assign opa = (state_q == S_FDOT) ? w_rd_q : g_rd_q;
	assign opb = (state_q == S_FDOT) ? x_rd_q :
		(state_q == S_IDOT) ? w_rd_q : (bias_q ? 16'sd1 : x_rd_q);

	assign w_ra = (state_q == S_FDOT) ? {r_q, k_q[IN_W-1:0]} :
		(state_q == S_IDOT) ? {k_q[OUT_W-1:0], c_q} : {r_q, c_q};
	assign x_ra = (state_q == S_FDOT) ? {s_q, k_q[IN_W-1:0]} : {k_q[SMP_W-1:0], c_q};
	assign g_ra = (state_q == S_IDOT) ? {b_q, k_q[OUT_W-1:0]} : {k_q[SMP_W-1:0], r_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_s2 <= opa * opb;
	end

	// result arithmetic
	assign f_full = acc_q + (ACC_W'(b_rd_q) <<< 8);
	assign f_res  = sat16(SAT_W'(f_full >>> 8));
	assign i_res  = sat16(SAT_W'(acc_q >>> 8));
	assign in_rng = ({1'b0, b_q} < nb) && ({1'b0, c_q} < ni);
	assign nxt_c  = c_q + 1'b1;
	assign nxt_b  = (c_q == IN_W'(IN_MAX - 1)) ? b_q + 1'b1 : b_q;
	assign nxt_rng = ({1'b0, nxt_b} < nb) && ({1'b0, nxt_c} < ni);

	always_comb begin
		if (!neg_q)
			dmag = bias_q ? (T_W+1)'(t_q >> 16) : (T_W+1)'(t_q >> 24);
		else if (bias_q)
			dmag = ({1'b0, t_q} + (T_W+1)'(17'h0FFFF)) >> 16;
		else
			dmag = ({1'b0, t_q} + (T_W+1)'(25'h0FFFFFF)) >> 24;
	end
	assign u_old = bias_q ? SAT_W'(b_rd_q) : SAT_W'(w_rd_q);
	assign u_new = neg_q ? u_old + SAT_W'(dmag) : u_old - SAT_W'(dmag);
	assign u_res = sat16(u_new);

	fcl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_UDIV),
		.dividend (acc_q[ACC_W-1] ? DIV_W'(-acc_q) : DIV_W'(acc_q)),
		.divisor  (nb),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_UMUL)
			t_q <= T_W'(quo * lr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			k_q     <= '0;
			r_q     <= '0;
			c_q     <= '0;
			b_q     <= '0;
			s_q     <= '0;
			bias_q  <= 1'b0;
			neg_q   <= 1'b0;
			acc_q   <= '0;
		end else begin
			if (issue)
				k_q <= k_q + 1'b1;
			if (v_s2)
				acc_q <= acc_q + ACC_W'(p_s2);
			unique case (state_q)
				S_CLR: begin
					{b_q, c_q} <= {b_q, c_q} + 1'b1;
					if ({b_q, c_q} == X_AW'(BATCH_MAX*IN_MAX - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					k_q   <= '0;
					acc_q <= '0;
					if (accept) begin
						case (in_data.mode)
							MODE_INPUT: begin
								if ({1'b0, in_data.col} == ni - 1'b1) begin
									s_q     <= in_data.sample;
									r_q     <= '0;
									state_q <= S_FDOT;
								end
							end
							MODE_GRAD: begin
								if ({1'b0, in_data.sample} == nb - 1'b1 &&
									{1'b0, in_data.row} == no - 1'b1) begin
									b_q     <= '0;
									c_q     <= '0;
									state_q <= S_IDOT;
								end
							end
							MODE_READ: begin
								s_q     <= in_data.sample;
								c_q     <= in_data.col;
								state_q <= S_RWAIT;
							end
							default: ;
						endcase
					end
				end
				S_FDOT: if (drained) state_q <= S_FFIN;
				S_FFIN: begin
					if (out_free) begin
						k_q   <= '0;
						acc_q <= '0;
						if ({1'b0, r_q} == no - 1'b1) begin
							state_q <= S_IDLE;
						end else begin
							r_q     <= r_q + 1'b1;
							state_q <= S_FDOT;
						end
					end
				end
				S_IDOT: if (drained) state_q <= S_IFIN;
				S_IFIN: begin
					k_q   <= '0;
					acc_q <= '0;
					c_q   <= nxt_c;
					b_q   <= nxt_b;
					if (b_q == SMP_W'(BATCH_MAX - 1) && c_q == IN_W'(IN_MAX - 1)) begin
						r_q     <= '0;
						c_q     <= '0;
						bias_q  <= 1'b1;
						state_q <= S_UDOT;
					end else if (nxt_rng) begin
						state_q <= S_IDOT;
					end
				end
				S_UDOT: if (drained) state_q <= S_UDIV;
				S_UDIV: begin
					neg_q   <= acc_q[ACC_W-1];
					state_q <= S_UWAIT;
				end
				S_UWAIT: if (div_done) state_q <= S_UMUL;
				S_UMUL: state_q <= S_UAPP;
				S_UAPP: begin
					k_q     <= '0;
					acc_q   <= '0;
					state_q <= S_UDOT;
					if (bias_q) begin
						bias_q <= 1'b0;
						c_q    <= '0;
					end else if ({1'b0, c_q} == ni - 1'b1) begin
						if ({1'b0, r_q} == no - 1'b1) begin
							state_q <= S_IDLE;
						end else begin
							r_q    <= r_q + 1'b1;
							bias_q <= 1'b1;
							c_q    <= '0;
						end
					end else begin
						c_q <= nxt_c;
					end
				end
				S_RWAIT: state_q <= S_ROUT;
				S_ROUT: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// memory ports
	assign w_we = (accept && in_data.mode == MODE_WEIGHT) || (state_q == S_UAPP && !bias_q);
	assign w_wa = (state_q == S_IDLE) ? {in_data.row, in_data.col} : {r_q, c_q};
	assign w_wd = (state_q == S_IDLE) ? in_data.value : u_res;
	assign b_we = (accept && in_data.mode == MODE_BIAS) || (state_q == S_UAPP && bias_q);
	assign b_wa = (state_q == S_IDLE) ? in_data.row : r_q;
	assign b_wd = (state_q == S_IDLE) ? in_data.value : u_res;
	assign ig_we = (state_q == S_CLR) || (state_q == S_IFIN);
	assign ig_wa = {b_q, c_q};
	assign ig_wd = (state_q == S_IFIN && in_rng) ? i_res : 16'sd0;

	always_ff @(posedge clk) begin
		if (w_we)
			w_mem[w_wa] <= w_wd;
		w_rd_q <= w_mem[w_ra];
	end

	always_ff @(posedge clk) begin
		if (b_we)
			b_mem[b_wa] <= b_wd;
		b_rd_q <= b_mem[r_q];
	end

	always_ff @(posedge clk) begin
		if (accept && in_data.mode == MODE_INPUT)
			x_mem[{in_data.sample, in_data.col}] <= in_data.value;
		x_rd_q <= x_mem[x_ra];
	end

	always_ff @(posedge clk) begin
		if (accept && in_data.mode == MODE_GRAD)
			g_mem[{in_data.sample, in_data.row}] <= in_data.value;
		g_rd_q <= g_mem[g_ra];
	end

	always_ff @(posedge clk) begin
		if (ig_we)
			ig_mem[ig_wa] <= ig_wd;
		ig_rd_q <= ig_mem[{s_q, c_q}];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (state_q == S_FFIN) || (state_q == S_ROUT);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && state_q == S_FFIN) begin
			out_q.kind   <= KIND_FWD;
			out_q.index  <= 6'(r_q);
			out_q.result <= f_res;
			out_q.last   <= ({1'b0, r_q} == no - 1'b1);
		end else if (out_free && state_q == S_ROUT) begin
			out_q.kind   <= KIND_READ;
			out_q.index  <= 6'(c_q);
			out_q.result <= ig_rd_q;
			out_q.last   <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
